// ----- rtl/pctc_pkg.sv -----
// pctc_pkg: shared types, widths and constants of the pressure/temperature compensation core
// no dependencies; imported by every module of the core
package pctc_pkg;

    localparam int COEFF_W   = 16;
    localparam int RAW_W     = 24;
    localparam int DT_W      = 25;   // raw temperature minus reference
    localparam int TPROD_W   = 42;   // dt times a 16-bit coefficient
    localparam int SQ_FULL_W = 50;   // dt squared
    localparam int Q_W       = 19;   // first-order temperature minus 2000
    localparam int CORR_W    = 42;   // sensitivity, offset and their corrections
    localparam int TI_W      = 18;   // second-order temperature correction
    localparam int SQ_W      = 36;   // squared temperature distances
    localparam int TEMP_W    = 21;   // compensated temperature before widening
    localparam int SPLIT_W   = 21;   // low slice of the sensitivity for the split multiply
    localparam int PPLO_W    = 45;
    localparam int PPHI_W    = 46;
    localparam int PROD_W    = 66;
    localparam int PDIV_W    = 45;
    localparam int P1_W      = 46;
    localparam int OUT_W     = 32;
    localparam int REG_IDX_W = 3;

    // rounding bias so that arithmetic shifts truncate toward zero
    localparam logic signed [TPROD_W-1:0] T_DIV_BIAS     = 42'sd8388607;
    localparam logic signed [TPROD_W-1:0] SENS_BIAS_V0   = 42'sd127;
    localparam logic signed [TPROD_W-1:0] SENS_BIAS_V1   = 42'sd255;
    localparam logic signed [TPROD_W-1:0] OFF_BIAS_V0    = 42'sd63;
    localparam logic signed [TPROD_W-1:0] OFF_BIAS_V1    = 42'sd127;
    localparam logic signed [PROD_W-1:0]  PROD_DIV_BIAS  = 66'sd2097151;
    localparam logic signed [P1_W-1:0]    P_BIAS_V0      = 46'sd32767;
    localparam logic signed [P1_W-1:0]    P_BIAS_V1      = 46'sd8191;

    localparam logic signed [TEMP_W-1:0]  TEMP_REF       = 21'sd2000;
    localparam logic signed [Q_W-1:0]     VLOW_Q         = -19'sd3500;
    localparam logic signed [Q_W:0]       VLOW_OFFSET    = 20'sd3500;

    // second-order correction multipliers
    localparam logic [CORR_W-1:0] K_OFF_LOW_V0  = 42'd61;
    localparam logic [CORR_W-1:0] K_SENS_LOW_V0 = 42'd29;
    localparam logic [CORR_W-1:0] K_OFF_LOW_V1  = 42'd3;
    localparam logic [CORR_W-1:0] K_SENS_LOW_V1 = 42'd5;
    localparam logic [CORR_W-1:0] K_OFF_VLO_V0  = 42'd17;
    localparam logic [CORR_W-1:0] K_SENS_VLO_V0 = 42'd9;
    localparam logic [CORR_W-1:0] K_OFF_VLO_V1  = 42'd7;
    localparam logic [CORR_W-1:0] K_SENS_VLO_V1 = 42'd4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SENS        = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5,
        REG_VARIANT     = 3'd6
    } pctc_reg_t;

    typedef struct packed {
        logic [COEFF_W-1:0] sens;
        logic [COEFF_W-1:0] offset;
        logic [COEFF_W-1:0] sens_temp;
        logic [COEFF_W-1:0] offset_temp;
        logic [COEFF_W-1:0] ref_temp;
        logic [COEFF_W-1:0] temp_slope;
        logic               variant;
    } pctc_cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } pctc_sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] temperature_centi;
        logic signed [OUT_W-1:0] pressure_value;
    } pctc_result_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [Q_W-1:0]    q;
        logic signed [CORR_W-1:0] sens;
        logic signed [CORR_W-1:0] off;
        logic [TI_W-1:0]          ti_lo;
        logic [TI_W-1:0]          ti_hi;
    } pctc_front_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [CORR_W-1:0] sens2;
        logic signed [CORR_W-1:0] off2;
        logic signed [TEMP_W-1:0] temp;
    } pctc_corr_t;

endpackage

// ----- rtl/pctc_front.sv -----
// pctc_front: first three stages - dt, the dt products, first-order sensitivity and offset
// depends on pctc_pkg
module pctc_front import pctc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  pctc_cfg_t    cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  pctc_sample_t in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output pctc_front_t  out_item
);

    logic a_en, b_en, c_en;
    logic a_valid_reg, b_valid_reg, c_valid_reg;

    logic [RAW_W-1:0]             a_d1_reg;
    logic signed [DT_W-1:0]       a_dt_reg, a_dt_next;

    logic [RAW_W-1:0]             b_d1_reg;
    logic signed [TPROD_W-1:0]    b_tprod_reg, b_tprod_next;
    logic signed [TPROD_W-1:0]    b_stc_reg, b_stc_next;
    logic signed [TPROD_W-1:0]    b_otc_reg, b_otc_next;
    logic signed [SQ_FULL_W-1:0]  b_sq_reg, b_sq_next;
    logic signed [COEFF_W:0]      slope_s, stc_s, otc_s;

    pctc_front_t                  c_item_reg, c_item_next;
    logic signed [TPROD_W-1:0]    tbias, stc_biased, otc_biased, stc_term, otc_term;
    logic [TPROD_W-1:0]           sens_base, off_base;
    logic [SQ_FULL_W-3:0]         dt2u;
    logic [SQ_FULL_W-1:0]         tri_sq;
    logic [SQ_FULL_W:0]           five_sq;

    assign c_en     = ~c_valid_reg | out_ready;
    assign b_en     = ~b_valid_reg | c_en;
    assign a_en     = ~a_valid_reg | b_en;
    assign in_ready = a_en;

    // stage a: distance from the reference temperature
    always_comb
    begin
        a_dt_next = $signed({1'b0, in_item.raw_temperature}) - $signed({1'b0, cfg.ref_temp, 8'h00});
    end

    // stage b: all products of dt
    always_comb
    begin
        slope_s      = $signed({1'b0, cfg.temp_slope});
        stc_s        = $signed({1'b0, cfg.sens_temp});
        otc_s        = $signed({1'b0, cfg.offset_temp});
        b_tprod_next = a_dt_reg * slope_s;
        b_stc_next   = a_dt_reg * stc_s;
        b_otc_next   = a_dt_reg * otc_s;
        b_sq_next    = a_dt_reg * a_dt_reg;
    end

    // stage c: scale the products, form sensitivity and offset
    always_comb
    begin
        tbias      = b_tprod_reg + (b_tprod_reg[TPROD_W-1] ? T_DIV_BIAS : 42'sd0);
        stc_biased = b_stc_reg + (b_stc_reg[TPROD_W-1] ?
                     (cfg.variant ? SENS_BIAS_V1 : SENS_BIAS_V0) : 42'sd0);
        otc_biased = b_otc_reg + (b_otc_reg[TPROD_W-1] ?
                     (cfg.variant ? OFF_BIAS_V1 : OFF_BIAS_V0) : 42'sd0);
        stc_term   = cfg.variant ? (stc_biased >>> 8) : (stc_biased >>> 7);
        otc_term   = cfg.variant ? (otc_biased >>> 7) : (otc_biased >>> 6);
        sens_base  = cfg.variant ? {11'd0, cfg.sens, 15'd0} : {10'd0, cfg.sens, 16'd0};
        off_base   = cfg.variant ? {10'd0, cfg.offset, 16'd0} : {9'd0, cfg.offset, 17'd0};

        // dt squared is never negative, so plain shifts truncate correctly
        dt2u    = b_sq_reg[SQ_FULL_W-3:0];
        tri_sq  = {2'b00, dt2u} + {1'b0, dt2u, 1'b0};
        five_sq = {3'b000, dt2u} + {1'b0, dt2u, 2'b00};

        c_item_next.d1    = b_d1_reg;
        c_item_next.q     = tbias[TPROD_W-1:23];
        c_item_next.sens  = $signed(sens_base) + stc_term;
        c_item_next.off   = $signed(off_base) + otc_term;
        c_item_next.ti_lo = {1'b0, tri_sq[SQ_FULL_W-1:33]};
        c_item_next.ti_hi = cfg.variant ? {6'd0, dt2u[47:36]} : {5'd0, five_sq[SQ_FULL_W:38]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_valid_reg <= in_valid;
            if (b_en)
                b_valid_reg <= a_valid_reg;
            if (c_en)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_d1_reg <= in_item.raw_pressure;
            a_dt_reg <= a_dt_next;
        end
        if (b_en)
        begin
            b_d1_reg    <= a_d1_reg;
            b_tprod_reg <= b_tprod_next;
            b_stc_reg   <= b_stc_next;
            b_otc_reg   <= b_otc_next;
            b_sq_reg    <= b_sq_next;
        end
        if (c_en)
            c_item_reg <= c_item_next;
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

// ----- rtl/pctc_corr.sv -----
// pctc_corr: three stages - band decision and squares, second-order terms, corrected values
// depends on pctc_pkg
module pctc_corr import pctc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  pctc_cfg_t   cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  pctc_front_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output pctc_corr_t  out_item
);

    logic d_en, e_en, f_en;
    logic d_valid_reg, e_valid_reg, f_valid_reg;

    // stage d
    logic [RAW_W-1:0]          d_d1_reg;
    logic signed [Q_W-1:0]     d_q_reg;
    logic signed [CORR_W-1:0]  d_sens_reg, d_off_reg;
    logic [TI_W-1:0]           d_ti_reg, d_ti_next;
    logic                      d_low_reg, d_low_next;
    logic                      d_vlow_reg, d_vlow_next;
    logic [SQ_W-1:0]           d_dl_reg, d_dl_next;
    logic [SQ_W-1:0]           d_dv_reg, d_dv_next;
    logic signed [2*Q_W-1:0]   dl_full;
    logic signed [Q_W:0]       qv;
    logic signed [2*Q_W+1:0]   dv_full;

    // stage e
    logic [RAW_W-1:0]          e_d1_reg;
    logic signed [Q_W-1:0]     e_q_reg;
    logic signed [CORR_W-1:0]  e_sens_reg, e_off_reg;
    logic [TI_W-1:0]           e_ti_reg;
    logic [CORR_W-1:0]         e_offi_reg, e_offi_next;
    logic [CORR_W-1:0]         e_sensi_reg, e_sensi_next;
    logic [CORR_W-1:0]         dl_x, dv_x;

    // stage f
    pctc_corr_t                f_item_reg, f_item_next;

    assign f_en     = ~f_valid_reg | out_ready;
    assign e_en     = ~e_valid_reg | f_en;
    assign d_en     = ~d_valid_reg | e_en;
    assign in_ready = d_en;

    // low band is t below 2000, that is q negative
    always_comb
    begin
        dl_full     = in_item.q * in_item.q;
        qv          = {in_item.q[Q_W-1], in_item.q} + VLOW_OFFSET;
        dv_full     = qv * qv;
        d_dl_next   = dl_full[SQ_W-1:0];
        d_dv_next   = dv_full[SQ_W-1:0];
        d_low_next  = in_item.q[Q_W-1];
        d_vlow_next = in_item.q < VLOW_Q;
        d_ti_next   = d_low_next ? in_item.ti_lo : in_item.ti_hi;
    end

    // all terms here are non-negative, so shifts truncate as required
    always_comb
    begin
        dl_x         = {6'd0, d_dl_reg};
        dv_x         = {6'd0, d_dv_reg};
        e_offi_next  = '0;
        e_sensi_next = '0;
        priority if (!d_low_reg)
        begin
            if (cfg.variant)
                e_offi_next = dl_x >> 4;
        end
        else if (!cfg.variant)
        begin
            e_offi_next  = (dl_x * K_OFF_LOW_V0) >> 4;
            e_sensi_next = (dl_x * K_SENS_LOW_V0) >> 4;
            if (d_vlow_reg)
            begin
                e_offi_next  = e_offi_next + dv_x * K_OFF_VLO_V0;
                e_sensi_next = e_sensi_next + dv_x * K_SENS_VLO_V0;
            end
        end
        else
        begin
            e_offi_next  = (dl_x * K_OFF_LOW_V1) >> 1;
            e_sensi_next = (dl_x * K_SENS_LOW_V1) >> 3;
            if (d_vlow_reg)
            begin
                e_offi_next  = e_offi_next + dv_x * K_OFF_VLO_V1;
                e_sensi_next = e_sensi_next + dv_x * K_SENS_VLO_V1;
            end
        end
    end

    always_comb
    begin
        f_item_next.d1    = e_d1_reg;
        f_item_next.sens2 = e_sens_reg - $signed(e_sensi_reg);
        f_item_next.off2  = e_off_reg - $signed(e_offi_reg);
        f_item_next.temp  = $signed({{(TEMP_W-Q_W){e_q_reg[Q_W-1]}}, e_q_reg}) + TEMP_REF
                            - $signed({3'b000, e_ti_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_en)
                d_valid_reg <= in_valid;
            if (e_en)
                e_valid_reg <= d_valid_reg;
            if (f_en)
                f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_en)
        begin
            d_d1_reg   <= in_item.d1;
            d_q_reg    <= in_item.q;
            d_sens_reg <= in_item.sens;
            d_off_reg  <= in_item.off;
            d_ti_reg   <= d_ti_next;
            d_low_reg  <= d_low_next;
            d_vlow_reg <= d_vlow_next;
            d_dl_reg   <= d_dl_next;
            d_dv_reg   <= d_dv_next;
        end
        if (e_en)
        begin
            e_d1_reg    <= d_d1_reg;
            e_q_reg     <= d_q_reg;
            e_sens_reg  <= d_sens_reg;
            e_off_reg   <= d_off_reg;
            e_ti_reg    <= d_ti_reg;
            e_offi_reg  <= e_offi_next;
            e_sensi_reg <= e_sensi_next;
        end
        if (f_en)
            f_item_reg <= f_item_next;
    end

    assign out_valid = f_valid_reg;
    assign out_item  = f_item_reg;

endmodule

// ----- rtl/pctc_press.sv -----
// pctc_press: five stages - split pressure multiply, merge, scale, offset and output register
// depends on pctc_pkg
module pctc_press import pctc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  pctc_cfg_t    cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  pctc_corr_t   in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output pctc_result_t out_item
);

    logic g_en, h_en, i_en, j_en, k_en;
    logic g_valid_reg, h_valid_reg, i_valid_reg, j_valid_reg, k_valid_reg;

    // stage g: d1 times sensitivity as two partial products
    logic [PPLO_W-1:0]         g_pplo_reg, g_pplo_next;
    logic signed [PPHI_W-1:0]  g_pphi_reg, g_pphi_next;
    logic signed [CORR_W-1:0]  g_off_reg;
    logic signed [TEMP_W-1:0]  g_temp_reg;

    // stage h: merged product
    logic signed [PROD_W-1:0]  h_prod_reg, h_prod_next;
    logic signed [CORR_W-1:0]  h_off_reg;
    logic signed [TEMP_W-1:0]  h_temp_reg;

    // stage i: product over 2^21
    logic signed [PROD_W-1:0]  prod_biased;
    logic signed [PDIV_W-1:0]  i_pdiv_reg, i_pdiv_next;
    logic signed [CORR_W-1:0]  i_off_reg;
    logic signed [TEMP_W-1:0]  i_temp_reg;

    // stage j: minus offset
    logic signed [P1_W-1:0]    j_p1_reg, j_p1_next;
    logic signed [TEMP_W-1:0]  j_temp_reg;

    // stage k: final scale, output register
    logic signed [P1_W-1:0]    p_biased, p_scaled;
    pctc_result_t              k_item_reg, k_item_next;

    assign k_en     = ~k_valid_reg | out_ready;
    assign j_en     = ~j_valid_reg | k_en;
    assign i_en     = ~i_valid_reg | j_en;
    assign h_en     = ~h_valid_reg | i_en;
    assign g_en     = ~g_valid_reg | h_en;
    assign in_ready = g_en;

    always_comb
    begin
        g_pplo_next = in_item.d1 * in_item.sens2[SPLIT_W-1:0];
        g_pphi_next = $signed({1'b0, in_item.d1}) * $signed(in_item.sens2[CORR_W-1:SPLIT_W]);
    end

    always_comb
    begin
        h_prod_next = ($signed({{(PROD_W-PPHI_W){g_pphi_reg[PPHI_W-1]}}, g_pphi_reg}) <<< SPLIT_W)
                      + $signed({{(PROD_W-PPLO_W){1'b0}}, g_pplo_reg});
    end

    always_comb
    begin
        prod_biased = h_prod_reg + (h_prod_reg[PROD_W-1] ? PROD_DIV_BIAS : 66'sd0);
        i_pdiv_next = prod_biased[PROD_W-1:21];
    end

    always_comb
    begin
        j_p1_next = {i_pdiv_reg[PDIV_W-1], i_pdiv_reg}
                    - {{(P1_W-CORR_W){i_off_reg[CORR_W-1]}}, i_off_reg};
    end

    always_comb
    begin
        p_biased = j_p1_reg + (j_p1_reg[P1_W-1] ?
                   (cfg.variant ? P_BIAS_V1 : P_BIAS_V0) : 46'sd0);
        p_scaled = cfg.variant ? (p_biased >>> 13) : (p_biased >>> 15);
        k_item_next.pressure_value    = p_scaled[OUT_W-1:0];
        k_item_next.temperature_centi = {{(OUT_W-TEMP_W){j_temp_reg[TEMP_W-1]}}, j_temp_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else
        begin
            if (g_en)
                g_valid_reg <= in_valid;
            if (h_en)
                h_valid_reg <= g_valid_reg;
            if (i_en)
                i_valid_reg <= h_valid_reg;
            if (j_en)
                j_valid_reg <= i_valid_reg;
            if (k_en)
                k_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_en)
        begin
            g_pplo_reg <= g_pplo_next;
            g_pphi_reg <= g_pphi_next;
            g_off_reg  <= in_item.off2;
            g_temp_reg <= in_item.temp;
        end
        if (h_en)
        begin
            h_prod_reg <= h_prod_next;
            h_off_reg  <= g_off_reg;
            h_temp_reg <= g_temp_reg;
        end
        if (i_en)
        begin
            i_pdiv_reg <= i_pdiv_next;
            i_off_reg  <= h_off_reg;
            i_temp_reg <= h_temp_reg;
        end
        if (j_en)
        begin
            j_p1_reg   <= j_p1_next;
            j_temp_reg <= i_temp_reg;
        end
        if (k_en)
            k_item_reg <= k_item_next;
    end

    assign out_valid = k_valid_reg;
    assign out_item  = k_item_reg;

endmodule

// ----- rtl/pressure_temperature_compensation_core.sv -----
// pressure_temperature_compensation_core: top level, calibration registers and the three pipeline parts
// depends on pctc_pkg, pctc_front, pctc_corr, pctc_press
//
//   channel   signals                                   item
//   sample    sample_valid / sample_ready / sample      raw pressure and raw temperature
//   result    result_valid / result_ready / result      compensated temperature and pressure
//   config    cfg_write / cfg_index / cfg_data          one calibration word per write
//
// eleven register stages, a to k; an item taken into stage a moves through them in order to the result
// one item per cycle when the result side keeps up; the 24 by 42 bit pressure product is
// formed as two partial products in one stage and merged in the next, which sets the depth
// of the back end
// every stage has a valid bit; a stage holds while the one after it is full and stalled,
// so empty stages keep filling behind a waiting result
// reset clears the valid bits and all calibration registers
module pressure_temperature_compensation_core import pctc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  pctc_sample_t         sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pctc_result_t         result,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_data
);

    pctc_cfg_t   cfg_reg, cfg_next;
    logic        front_valid, front_ready;
    pctc_front_t front_item;
    logic        corr_valid, corr_ready;
    pctc_corr_t  corr_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (pctc_reg_t'(cfg_index))
                REG_SENS:        cfg_next.sens        = cfg_data;
                REG_OFFSET:      cfg_next.offset      = cfg_data;
                REG_SENS_TEMP:   cfg_next.sens_temp   = cfg_data;
                REG_OFFSET_TEMP: cfg_next.offset_temp = cfg_data;
                REG_REF_TEMP:    cfg_next.ref_temp    = cfg_data;
                REG_TEMP_SLOPE:  cfg_next.temp_slope  = cfg_data;
                REG_VARIANT:     cfg_next.variant     = cfg_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pctc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .in_item   (sample),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    pctc_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_item  (corr_item)
    );

    pctc_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (corr_valid),
        .in_ready  (corr_ready),
        .in_item   (corr_item),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (result)
    );

endmodule
